// ===== src/pse_pkg.sv =====
`timescale 1ns / 1ps
package pse_pkg;
   localparam int CAPACITY_DEF = 1024;
   localparam int MAX_PER_ITEM_DEF = 64;
   localparam logic [63:0] GOLDEN = 64'h9e3779b97f4a7c15;
   localparam logic [63:0] MIX_A = 64'hff51afd7ed558ccd;
   localparam logic [63:0] MIX_B = 64'hc4ceb9fe1a85ec53;
   localparam logic [27:0] ACC_ONE = 28'd256;
   localparam logic [27:0] ACC_MAX = 28'hFFFFFFF;

   localparam logic [1:0] REQ_TICK = 2'd0;
   localparam logic [1:0] REQ_BURST = 2'd1;
   localparam logic [1:0] REQ_RELEASE = 2'd2;

   localparam logic [2:0] REG_RATE = 3'd0;
   localparam logic [2:0] REG_SPREAD = 3'd1;
   localparam logic [2:0] REG_VLO = 3'd2;
   localparam logic [2:0] REG_VHI = 3'd3;
   localparam logic [2:0] REG_LLO = 3'd4;
   localparam logic [2:0] REG_LHI = 3'd5;
   localparam logic [2:0] REG_SEED = 3'd6;

   typedef struct packed {
      logic        start;
      logic [63:0] seed_val;
      logic        seed_load;
   } rng_ctl_type;
endpackage

// ===== src/pse_mul.sv =====
`timescale 1ns / 1ps
// 64x64 low-product multiplier built from three 32x32 partial products
module pse_mul import pse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [63:0] a,
   input  logic [63:0] b,
   output logic        done,
   output logic [63:0] prod
);
   logic [2:0]  step_ff, step_in;
   logic [63:0] a_ff, b_ff, acc_ff, acc_in;
   logic [31:0] ma, mb;
   logic [63:0] pp;

   always_comb begin
      ma = a_ff[31:0];
      mb = b_ff[31:0];
      unique case (step_ff)
         3'd1: begin ma = a_ff[31:0]; mb = b_ff[31:0]; end
         3'd2: begin ma = a_ff[63:32]; mb = b_ff[31:0]; end
         3'd3: begin ma = a_ff[31:0]; mb = b_ff[63:32]; end
         default: begin ma = a_ff[31:0]; mb = b_ff[31:0]; end
      endcase
      pp = 64'(ma) * 64'(mb);
      acc_in = acc_ff;
      unique case (step_ff)
         3'd1: acc_in = pp;
         3'd2: acc_in = acc_ff + {pp[31:0], 32'd0};
         3'd3: acc_in = acc_ff + {pp[31:0], 32'd0};
         default: acc_in = acc_ff;
      endcase
      step_in = step_ff;
      if (start) step_in = 3'd1;
      else if (step_ff != 3'd0 && step_ff != 3'd4) step_in = step_ff + 3'd1;
      else if (step_ff == 3'd4) step_in = 3'd0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= 3'd0;
      end else begin
         step_ff <= step_in;
      end
      if (start) begin
         a_ff <= a;
         b_ff <= b;
      end
      acc_ff <= acc_in;
   end

   assign done = (step_ff == 3'd4);
   assign prod = acc_ff;
endmodule

// ===== src/pse_rng.sv =====
`timescale 1ns / 1ps
// one draw: add, mix, multiply, mix, multiply, mix on the shared multiplier
module pse_rng import pse_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  rng_ctl_type ctl,
   output logic        done,
   output logic [23:0] draw
);
   typedef enum logic [1:0] {R_IDLE, R_M1, R_M2} rstate_type;
   rstate_type st_ff;
   logic [63:0] state_ff;
   logic        done_ff;
   logic        mstart;
   logic [63:0] ma, mb, prod;
   logic        mdone;
   logic [63:0] x0;

   assign x0 = state_ff + GOLDEN;

   pse_mul u_mul (
      .clock(clock), .reset(reset), .start(mstart), .a(ma), .b(mb),
      .done(mdone), .prod(prod)
   );

   always_comb begin
      mstart = 1'b0;
      ma = x0 ^ (x0 >> 33);
      mb = MIX_A;
      if (st_ff == R_IDLE && ctl.start) mstart = 1'b1;
      if (st_ff == R_M1 && mdone) begin
         mstart = 1'b1;
         ma = prod ^ (prod >> 33);
         mb = MIX_B;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= R_IDLE;
         state_ff <= 64'd0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.seed_load) state_ff <= ctl.seed_val;
         unique case (st_ff)
            R_IDLE: if (ctl.start) st_ff <= R_M1;
            R_M1: if (mdone) st_ff <= R_M2;
            R_M2: if (mdone) begin
               state_ff <= prod ^ (prod >> 33);
               done_ff <= 1'b1;
               st_ff <= R_IDLE;
            end
            default: st_ff <= R_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign draw = state_ff[23:0];
endmodule

// ===== src/particle_spawn_engine.sv =====
`timescale 1ns / 1ps
// Each particle result takes seven generator draws (two multiplies each on one shared
// 32x32 multiplier) plus the decide, pop, slot read and result states. Release and
// status results pass one state (S_PUSH or S_DECIDE) and S_OUT after acceptance, a
// skipped tick S_OUT alone. One transaction at a time: req_stall is high outside
// S_IDLE. Synchronous reset first runs a clearing pass over all CAPACITY entries of
// the free-slot stack.
module particle_spawn_engine import pse_pkg::*; #(
   parameter int CAPACITY = CAPACITY_DEF,
   parameter int MAX_PER_ITEM = MAX_PER_ITEM_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_psel,
   input  logic         csr_penable,
   input  logic         csr_pwrite,
   input  logic [5:0]   csr_paddr,
   input  logic [63:0]  csr_pwdata,
   output logic [63:0]  csr_prdata,
   output logic         csr_pready,
   input  logic         req_valid,
   output logic         req_stall,
   input  logic [1:0]   req_req_type,
   input  logic [15:0]  req_time_step,
   input  logic [6:0]   req_burst_count,
   input  logic [9:0]   req_release_slot,
   input  logic signed [15:0] req_origin_x,
   input  logic signed [15:0] req_origin_y,
   input  logic signed [15:0] req_origin_z,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output logic [9:0]   rsp_slot_index,
   output logic signed [15:0] rsp_pos_x,
   output logic signed [15:0] rsp_pos_y,
   output logic signed [15:0] rsp_pos_z,
   output logic signed [15:0] rsp_vel_x,
   output logic signed [15:0] rsp_vel_y,
   output logic signed [15:0] rsp_vel_z,
   output logic [15:0]  rsp_life_span,
   output logic         rsp_particle_valid,
   output logic         rsp_last_of_run,
   output logic         rsp_clamped,
   output logic         rsp_at_capacity
);
   localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int DW = $clog2(CAPACITY + 1);
   localparam int CW = $clog2(MAX_PER_ITEM + 1);

   typedef enum logic [3:0] {
      S_CLEAR, S_IDLE, S_DECIDE, S_POP, S_POPRD, S_DRAW, S_WAIT, S_SCALE,
      S_OUT, S_HOLD, S_PUSH
   } state_type;

   state_type st_ff;
   logic [19:0] rate_ff;
   logic [47:0] spread_ff, vlo_ff, vhi_ff;
   logic [15:0] llo_ff, lhi_ff;
   logic [63:0] seed_ff;
   logic [27:0] acc_ff;
   logic [DW-1:0] depth_ff;
   logic [AW-1:0] clr_ff;
   logic [AW-1:0] mem [CAPACITY];
   logic [AW-1:0] rd_ff;
   logic [AW-1:0] slot_ff;

   logic [1:0]  typ_ff;
   logic [6:0]  cnt_ff;
   logic [9:0]  rel_ff;
   logic [15:0] ox_ff, oy_ff, oz_ff;
   logic [CW-1:0] n_ff;
   logic [2:0]  k_ff;
   logic [23:0] u_ff;
   logic [15:0] samp_ff [7];
   logic        last_ff, clamp_ff, atcap_ff, pvalid_ff;

   // config port
   logic wr;
   logic [2:0] widx;
   assign csr_pready = 1'b1;
   assign wr = csr_psel && csr_penable && csr_pwrite;
   assign widx = csr_paddr[5:3];

   always_comb begin
      unique case (widx)
         REG_RATE: csr_prdata = 64'(rate_ff);
         REG_SPREAD: csr_prdata = 64'(spread_ff);
         REG_VLO: csr_prdata = 64'(vlo_ff);
         REG_VHI: csr_prdata = 64'(vhi_ff);
         REG_LLO: csr_prdata = 64'(llo_ff);
         REG_LHI: csr_prdata = 64'(lhi_ff);
         REG_SEED: csr_prdata = seed_ff;
         default: csr_prdata = 64'd0;
      endcase
   end

   // generator
   rng_ctl_type rctl;
   logic rdone;
   logic [23:0] rdraw;
   assign rctl.start = (st_ff == S_DRAW);
   assign rctl.seed_load = wr && widx == REG_SEED;
   assign rctl.seed_val = csr_pwdata;
   pse_rng u_rng (.clock(clock), .reset(reset), .ctl(rctl), .done(rdone), .draw(rdraw));

   // bounds for sample k
   logic signed [17:0] lo, hi, slo, shi, diff;
   logic signed [15:0] a16, b16;
   always_comb begin
      a16 = 16'sd0;
      b16 = 16'sd0;
      lo = 18'sd0;
      hi = 18'sd0;
      unique case (k_ff)
         3'd0, 3'd1, 3'd2: begin
            a16 = spread_ff[16*k_ff +: 16];
            hi = 18'(a16);
            lo = -hi;
         end
         3'd3, 3'd4, 3'd5: begin
            a16 = vlo_ff[16*(k_ff-3'd3) +: 16];
            b16 = vhi_ff[16*(k_ff-3'd3) +: 16];
            lo = 18'(a16);
            hi = 18'(b16);
         end
         default: begin
            lo = $signed({2'b00, llo_ff});
            hi = $signed({2'b00, lhi_ff});
         end
      endcase
      if (lo > hi) begin
         slo = hi; shi = lo;
      end else begin
         slo = lo; shi = hi;
      end
      diff = shi - slo;
   end
   logic [41:0] scaled;
   logic signed [17:0] samp;
   assign scaled = 42'(u_ff) * 42'(diff[16:0]);
   assign samp = slo + $signed({1'b0, scaled[40:24]});

   // tick addend
   logic [35:0] prodr;
   logic [28:0] accsum;
   assign prodr = 36'(req_time_step) * 36'(rate_ff);
   assign accsum = 29'(acc_ff) + 29'(prodr[35:16]);

   logic done_item;
   logic more;
   logic tick_cap;
   logic fin;
   assign req_stall = (st_ff != S_IDLE);
   assign rsp_valid = (st_ff == S_HOLD);

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_CLEAR;
         rate_ff <= '0; spread_ff <= '0; vlo_ff <= '0; vhi_ff <= '0;
         llo_ff <= '0; lhi_ff <= '0; seed_ff <= '0;
         acc_ff <= '0;
         depth_ff <= DW'(CAPACITY);
         clr_ff <= '0;
      end else begin
         if (wr) begin
            unique case (widx)
               REG_RATE: rate_ff <= csr_pwdata[19:0];
               REG_SPREAD: spread_ff <= csr_pwdata[47:0];
               REG_VLO: vlo_ff <= csr_pwdata[47:0];
               REG_VHI: vhi_ff <= csr_pwdata[47:0];
               REG_LLO: llo_ff <= csr_pwdata[15:0];
               REG_LHI: lhi_ff <= csr_pwdata[15:0];
               REG_SEED: seed_ff <= csr_pwdata;
               default: ;
            endcase
         end
         unique case (st_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + AW'(1);
               if (32'(clr_ff) == CAPACITY - 1) st_ff <= S_IDLE;
            end
            S_IDLE: if (req_valid) begin
               typ_ff <= req_req_type;
               cnt_ff <= req_burst_count;
               rel_ff <= req_release_slot;
               ox_ff <= req_origin_x; oy_ff <= req_origin_y; oz_ff <= req_origin_z;
               n_ff <= '0;
               clamp_ff <= 1'b0;
               atcap_ff <= 1'b0;
               if (req_req_type == REQ_TICK && rate_ff != 20'd0 && req_time_step != 16'd0)
                  acc_ff <= accsum[28] ? ACC_MAX : accsum[27:0];
               if (req_req_type == REQ_RELEASE) begin
                  st_ff <= S_PUSH;
               end else if (req_req_type == REQ_TICK
                            && (rate_ff == 20'd0 || req_time_step == 16'd0)) begin
                  pvalid_ff <= 1'b0; last_ff <= 1'b1; st_ff <= S_OUT;
               end else begin
                  st_ff <= S_DECIDE;
               end
            end
            S_PUSH: begin
               if (32'(rel_ff) < CAPACITY && 32'(depth_ff) < CAPACITY) begin
                  depth_ff <= depth_ff + DW'(1);
               end
               pvalid_ff <= 1'b0; last_ff <= 1'b1;
               st_ff <= S_OUT;
            end
            S_DECIDE: begin
               if (typ_ff == REQ_TICK) begin
                  if (acc_ff < ACC_ONE || 32'(n_ff) >= MAX_PER_ITEM) begin
                     pvalid_ff <= 1'b0; last_ff <= 1'b1; st_ff <= S_OUT;
                  end else if (depth_ff == '0) begin
                     acc_ff <= '0; atcap_ff <= 1'b1;
                     pvalid_ff <= 1'b0; last_ff <= 1'b1; st_ff <= S_OUT;
                  end else begin
                     acc_ff <= acc_ff - ACC_ONE;
                     st_ff <= S_POP;
                  end
               end else if (typ_ff == REQ_BURST) begin
                  if (32'(n_ff) < 32'(cnt_ff) && depth_ff != '0
                      && 32'(n_ff) < MAX_PER_ITEM) begin
                     st_ff <= S_POP;
                  end else begin
                     clamp_ff <= (cnt_ff != 7'd0) && (32'(n_ff) < 32'(cnt_ff));
                     pvalid_ff <= 1'b0; last_ff <= 1'b1; st_ff <= S_OUT;
                  end
               end else begin
                  pvalid_ff <= 1'b0; last_ff <= 1'b1; st_ff <= S_OUT;
               end
            end
            S_POP: begin
               depth_ff <= depth_ff - DW'(1);
               k_ff <= 3'd0;
               st_ff <= S_POPRD;
            end
            S_POPRD: begin
               slot_ff <= rd_ff;
               st_ff <= S_DRAW;
            end
            S_DRAW: st_ff <= S_WAIT;
            S_WAIT: if (rdone) begin
               u_ff <= rdraw;
               st_ff <= S_SCALE;
            end
            S_SCALE: begin
               samp_ff[k_ff] <= samp[15:0];
               if (k_ff == 3'd6) begin
                  n_ff <= n_ff + CW'(1);
                  pvalid_ff <= 1'b1;
                  last_ff <= 1'b0;
                  st_ff <= S_HOLD;
               end else begin
                  k_ff <= k_ff + 3'd1;
                  st_ff <= S_DRAW;
               end
            end
            S_OUT: st_ff <= S_HOLD;
            S_HOLD: if (!rsp_stall) begin
               if (pvalid_ff && tick_cap) acc_ff <= '0;
               if (done_item) st_ff <= S_IDLE;
               else st_ff <= S_DECIDE;
            end
            default: st_ff <= S_IDLE;
         endcase
      end
   end

   // decide at each particle whether it ends the transaction
   always_comb begin
      if (typ_ff == REQ_TICK)
         more = acc_ff >= ACC_ONE && 32'(n_ff) < MAX_PER_ITEM;
      else
         more = 32'(n_ff) < 32'(cnt_ff) && depth_ff != '0 && 32'(n_ff) < MAX_PER_ITEM;
   end
   assign tick_cap = (typ_ff == REQ_TICK) && more && depth_ff == '0;
   assign fin = pvalid_ff ? (!more || tick_cap) : 1'b1;
   assign done_item = last_ff || fin;

   always_ff @(posedge clock) begin
      if (st_ff == S_CLEAR) mem[clr_ff] <= AW'(CAPACITY - 1) - clr_ff;
      else if (st_ff == S_PUSH && 32'(rel_ff) < CAPACITY && 32'(depth_ff) < CAPACITY)
         mem[depth_ff[AW-1:0]] <= rel_ff[AW-1:0];
      rd_ff <= mem[AW'(depth_ff - DW'(1))];
   end

   assign rsp_slot_index = pvalid_ff ? 10'(slot_ff) : 10'd0;
   assign rsp_pos_x = pvalid_ff ? ox_ff + samp_ff[0] : 16'sd0;
   assign rsp_pos_y = pvalid_ff ? oy_ff + samp_ff[1] : 16'sd0;
   assign rsp_pos_z = pvalid_ff ? oz_ff + samp_ff[2] : 16'sd0;
   assign rsp_vel_x = pvalid_ff ? samp_ff[3] : 16'sd0;
   assign rsp_vel_y = pvalid_ff ? samp_ff[4] : 16'sd0;
   assign rsp_vel_z = pvalid_ff ? samp_ff[5] : 16'sd0;
   assign rsp_life_span = pvalid_ff ? samp_ff[6] : 16'd0;
   assign rsp_particle_valid = pvalid_ff;
   assign rsp_last_of_run = fin;
   assign rsp_clamped = fin && !pvalid_ff && clamp_ff
                        || (pvalid_ff && fin && typ_ff == REQ_BURST && 32'(n_ff) < 32'(cnt_ff));
   assign rsp_at_capacity = pvalid_ff ? tick_cap : atcap_ff;
endmodule
